// ----- sv/assert_macros.svh -----
// assert_macros.svh: concurrent assertion macros shared by the checkers.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, idle while reset is held.
`define AST_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, idle while reset is held.
`define AST_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- sv/u2a_pkg.sv -----
// u2a_pkg: widths, character codes and the code point fold for the UTF-8 folder.
// No dependencies; used by utf8_to_ascii_folder.
`default_nettype none

package u2a_pkg;

	localparam int BYTE_W = 8;
	localparam int CHAR_W = 7;
	localparam int CP_W   = 21;

	localparam logic [CHAR_W-1:0] CH_SPACE  = 7'h20;
	localparam logic [CHAR_W-1:0] CH_DQUOTE = 7'h22;
	localparam logic [CHAR_W-1:0] CH_HASH   = 7'h23;
	localparam logic [CHAR_W-1:0] CH_QUOTE  = 7'h27;
	localparam logic [CHAR_W-1:0] CH_STAR   = 7'h2A;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 7'h2B;
	localparam logic [CHAR_W-1:0] CH_DASH   = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT    = 7'h2E;
	localparam logic [CHAR_W-1:0] CH_LT     = 7'h3C;
	localparam logic [CHAR_W-1:0] CH_GT     = 7'h3E;
	localparam logic [CHAR_W-1:0] CH_QMARK  = 7'h3F;
	localparam logic [CHAR_W-1:0] CH_CARET  = 7'h5E;
	localparam logic [CHAR_W-1:0] CH_LO_O   = 7'h6F;
	localparam logic [CHAR_W-1:0] CH_LO_V   = 7'h76;
	localparam logic [CHAR_W-1:0] CH_LO_X   = 7'h78;
	localparam logic [CHAR_W-1:0] CH_BAR    = 7'h7C;
	localparam logic [CHAR_W-1:0] CH_TILDE  = 7'h7E;

	// Base letters for U+00C0..U+00FF, leftmost character is entry 0
	localparam logic [0:63][BYTE_W-1:0] LATIN1_FOLD =
		{"AAAAAAACEEEEIIII", "DNOOOOOxOUUUUYPs",
		 "aaaaaaaceeeeiiii", "dnooooo/ouuuuypy"};

	function automatic logic [CHAR_W-1:0] fold_point(input logic [CP_W-1:0] cp);
		logic [BYTE_W-1:0] lat;
		lat = LATIN1_FOLD[cp[5:0]];
		if (cp < 21'h80) begin
			return cp[CHAR_W-1:0];
		end
		if (cp inside {[21'hC0:21'hFF]}) begin
			return lat[CHAR_W-1:0];
		end
		case (cp)
			21'h00A0: return CH_SPACE;
			21'h2018, 21'h2019: return CH_QUOTE;
			21'h201C, 21'h201D: return CH_DQUOTE;
			21'h2013, 21'h2014: return CH_DASH;
			21'h2026: return CH_TILDE;
			21'h2022, 21'h00B7: return CH_DOT;
			21'h2190: return CH_LT;
			21'h2191: return CH_CARET;
			21'h2192: return CH_GT;
			21'h2193: return CH_LO_V;
			21'h2713, 21'h2714: return CH_LO_V;
			21'h2715, 21'h2717, 21'h2718: return CH_LO_X;
			21'h00B0: return CH_LO_O;
			21'h00B1: return CH_PLUS;
			21'h00BB: return CH_GT;
			21'h00AB: return CH_LT;
			default: ;
		endcase
		if (cp inside {[21'h2500:21'h257F]}) begin
			if (cp inside {21'h2500, 21'h2501, 21'h2504, 21'h2505,
					21'h2508, 21'h2509, 21'h254C, 21'h254D}) begin
				return CH_DASH;
			end
			if (cp inside {21'h2502, 21'h2503, 21'h2506, 21'h2507,
					21'h250A, 21'h250B, 21'h254E, 21'h254F}) begin
				return CH_BAR;
			end
			return CH_PLUS;
		end
		if (cp inside {[21'h2580:21'h259F]}) begin
			return CH_HASH;
		end
		if (cp inside {[21'h25A0:21'h25FF], [21'h2600:21'h27BF]}) begin
			return CH_STAR;
		end
		return CH_QMARK;
	endfunction

endpackage

`default_nettype wire

// ----- sv/utf8_to_ascii_folder.sv -----
// A byte request passes the input register and then the result register to become its character.
// One byte per cycle unless stalled; bytes that close no code point give no character.
// The input stalls only while the result register is full and itself stalled.
// Reset (arst_n low) empties both registers and closes any open sequence.
// Decoder state updates as each byte leaves the input register, in arrival order.
`default_nettype none

module utf8_to_ascii_folder import u2a_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  logic [BYTE_W-1:0] in_byte,
	output logic              char_valid,
	input  logic              char_stall,
	output logic [CHAR_W-1:0] ascii_char
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              char_valid_q;
	logic [CHAR_W-1:0] char_q;
	logic [CP_W-1:0]   pc_q;
	logic [1:0]        rem_q;

	logic              adv;
	logic [CP_W-1:0]   pc_d;
	logic [CP_W-1:0]   cp_shift;
	logic [1:0]        rem_d;
	logic              res_valid;
	logic [CHAR_W-1:0] res_char;

	assign adv        = !char_valid_q || !char_stall;
	assign byte_stall = valid_s1 && !adv;
	assign char_valid = char_valid_q;
	assign ascii_char = char_q;
	assign cp_shift   = {pc_q[CP_W-7:0], byte_s1[5:0]};

	always_comb begin
		pc_d      = pc_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res_char  = byte_s1[CHAR_W-1:0];
		if (rem_q != 2'd0 && byte_s1[7:6] == 2'b10) begin
			rem_d = rem_q - 2'd1;
			if (rem_q == 2'd1) begin
				res_valid = 1'b1;
				res_char  = fold_point(cp_shift);
				pc_d      = '0;
			end else begin
				pc_d = cp_shift;
			end
		end else begin
			// no sequence open, or cut short: take this byte afresh
			pc_d  = '0;
			rem_d = 2'd0;
			if (byte_s1 == '0) begin
				res_valid = 1'b0;
			end else if (!byte_s1[7]) begin
				res_valid = 1'b1;
			end else if (byte_s1[7:5] == 3'b110) begin
				pc_d  = CP_W'(byte_s1[4:0]);
				rem_d = 2'd1;
			end else if (byte_s1[7:4] == 4'b1110) begin
				pc_d  = CP_W'(byte_s1[3:0]);
				rem_d = 2'd2;
			end else if (byte_s1[7:3] == 5'b11110) begin
				pc_d  = CP_W'(byte_s1[2:0]);
				rem_d = 2'd3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			char_valid_q <= 1'b0;
			pc_q         <= '0;
			rem_q        <= 2'd0;
		end else begin
			if (!byte_stall) begin
				valid_s1 <= byte_valid;
			end
			if (adv) begin
				char_valid_q <= valid_s1 && res_valid;
			end
			if (valid_s1 && adv) begin
				pc_q  <= pc_d;
				rem_q <= rem_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= in_byte;
		end
		if (adv && valid_s1 && res_valid) begin
			char_q <= res_char;
		end
	end

endmodule

`default_nettype wire

// ----- sv/u2a_checker.sv -----
// u2a_checker: port-level checks on utf8_to_ascii_folder, attached by bind.
// Depends on assert_macros.svh and u2a_pkg.
`include "assert_macros.svh"
`default_nettype none

module u2a_checker import u2a_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              byte_valid,
	input logic              byte_stall,
	input logic [BYTE_W-1:0] in_byte,
	input logic              char_valid,
	input logic              char_stall,
	input logic [CHAR_W-1:0] ascii_char
);

	// a stalled character stays offered and unchanged
	`AST_NEXT(a_char_hold, char_valid && char_stall, char_valid)
	`AST_NEXT(a_char_stable, char_valid && char_stall, $stable(ascii_char))

	// a stalled byte request stays offered and unchanged
	`AST_NEXT(a_byte_stable, byte_valid && byte_stall, byte_valid && $stable(in_byte))

	// backpressure only comes from a full, stalled result register
	`AST_IMPLY(a_stall_cause, byte_stall, char_valid && char_stall)

	// a fresh character needs a request taken earlier, through the input register
	`AST_IMPLY(a_char_source, $rose(char_valid), $past(byte_valid && !byte_stall, 2))

endmodule

bind utf8_to_ascii_folder u2a_checker u_u2a_checker (.*);

`default_nettype wire

// ----- sim/tb_top.sv -----
// tb_top: self-checking bench for utf8_to_ascii_folder with random byte streams and stalls.
// Depends on u2a_pkg for widths and character codes; a scoreboard class predicts each character.

module tb_top import u2a_pkg::*;;

	class fold_predictor;
		logic [CP_W-1:0]   cp_acc;
		logic [1:0]        conts_left;
		logic [CHAR_W-1:0] due_chars[$];
		int                bad_chars;

		function new();
			cp_acc     = '0;
			conts_left = '0;
			bad_chars  = 0;
		endfunction

		function logic [CHAR_W-1:0] fold(input logic [CP_W-1:0] cp);
			string latin;
			byte   ch;
			latin = "AAAAAAACEEEEIIIIDNOOOOOxOUUUUYPsaaaaaaaceeeeiiiidnooooo/ouuuuypy";
			if (cp < 21'h80) begin
				return cp[CHAR_W-1:0];
			end
			if (cp >= 21'hC0 && cp <= 21'hFF) begin
				ch = latin.getc(int'(cp) - 'hC0);
				return ch[CHAR_W-1:0];
			end
			case (cp)
				21'h00A0: return CH_SPACE;
				21'h2018, 21'h2019: return CH_QUOTE;
				21'h201C, 21'h201D: return CH_DQUOTE;
				21'h2013, 21'h2014: return CH_DASH;
				21'h2026: return CH_TILDE;
				21'h2022, 21'h00B7: return CH_DOT;
				21'h2190, 21'h00AB: return CH_LT;
				21'h2191: return CH_CARET;
				21'h2192, 21'h00BB: return CH_GT;
				21'h2193, 21'h2713, 21'h2714: return CH_LO_V;
				21'h2715, 21'h2717, 21'h2718: return CH_LO_X;
				21'h00B0: return CH_LO_O;
				21'h00B1: return CH_PLUS;
				default: ;
			endcase
			if (cp >= 21'h2500 && cp <= 21'h257F) begin
				case (cp)
					21'h2500, 21'h2501, 21'h2504, 21'h2505,
					21'h2508, 21'h2509, 21'h254C, 21'h254D: return CH_DASH;
					21'h2502, 21'h2503, 21'h2506, 21'h2507,
					21'h250A, 21'h250B, 21'h254E, 21'h254F: return CH_BAR;
					default: return CH_PLUS;
				endcase
			end
			if (cp >= 21'h2580 && cp <= 21'h259F) begin
				return CH_HASH;
			end
			if (cp >= 21'h25A0 && cp <= 21'h27BF) begin
				return CH_STAR;
			end
			return CH_QMARK;
		endfunction

		// one accepted byte request
		function void take_byte(input logic [BYTE_W-1:0] b);
			if (conts_left != 0) begin
				if (b[7:6] == 2'b10) begin
					cp_acc     = {cp_acc[CP_W-7:0], b[5:0]};
					conts_left = conts_left - 2'd1;
					if (conts_left == 0) begin
						due_chars.push_back(fold(cp_acc));
						cp_acc = '0;
					end
					return;
				end
				// cut short: drop the partial point, treat this byte as new
				cp_acc     = '0;
				conts_left = '0;
			end
			if (b == 0) begin
				return;
			end
			if (b < 8'h80) begin
				due_chars.push_back(b[CHAR_W-1:0]);
			end else if (b[7:5] == 3'b110) begin
				cp_acc     = {16'b0, b[4:0]};
				conts_left = 2'd1;
			end else if (b[7:4] == 4'b1110) begin
				cp_acc     = {17'b0, b[3:0]};
				conts_left = 2'd2;
			end else if (b[7:3] == 5'b11110) begin
				cp_acc     = {18'b0, b[2:0]};
				conts_left = 2'd3;
			end
		endfunction

		function void match_char(input logic [CHAR_W-1:0] got);
			logic [CHAR_W-1:0] want;
			if (due_chars.size() == 0) begin
				bad_chars++;
				if (bad_chars <= 10) begin
					$display("character 0x%02h arrived with none due", got);
				end
				return;
			end
			want = due_chars.pop_front();
			if (got !== want) begin
				bad_chars++;
				if (bad_chars <= 10) begin
					$display("ascii_char mismatch: expected 0x%02h got 0x%02h", want, got);
				end
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              byte_valid;
	logic              byte_stall;
	logic [BYTE_W-1:0] in_byte;
	logic              char_valid;
	logic              char_stall;
	logic [CHAR_W-1:0] ascii_char;

	fold_predictor fp = new();
	bit            idle_on = 1'b1;
	bit            long_hold_go = 1'b0;
	int            good_bytes = 0;
	logic [CP_W-1:0] notable_cps[$];

	utf8_to_ascii_folder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.in_byte    (in_byte),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.ascii_char (ascii_char)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		while (idle_on && $urandom_range(0, 99) < 8) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		in_byte    <= b;
		@(posedge clk);
		while (byte_stall) begin
			@(posedge clk);
		end
		fp.take_byte(b);
	endtask

	// UTF-8 encoding of cp in nbytes bytes; more than needed gives an overlong form.
	// keep < nbytes cuts the sequence after that many bytes.
	task automatic send_code_point(input logic [CP_W-1:0] cp, input int nbytes, input int keep);
		logic [BYTE_W-1:0] seq[4];
		case (nbytes)
			1: seq[0] = cp[7:0];
			2: begin
				seq[0] = {3'b110, cp[10:6]};
				seq[1] = {2'b10, cp[5:0]};
			end
			3: begin
				seq[0] = {4'b1110, cp[15:12]};
				seq[1] = {2'b10, cp[11:6]};
				seq[2] = {2'b10, cp[5:0]};
			end
			default: begin
				seq[0] = {5'b11110, cp[20:18]};
				seq[1] = {2'b10, cp[17:12]};
				seq[2] = {2'b10, cp[11:6]};
				seq[3] = {2'b10, cp[5:0]};
			end
		endcase
		for (int i = 0; i < keep; i++) begin
			send_byte(seq[i]);
		end
		if (keep == nbytes) begin
			good_bytes += nbytes;
		end
	endtask

	function automatic int min_len(input logic [CP_W-1:0] cp);
		if (cp < 21'h80) return 1;
		if (cp < 21'h800) return 2;
		if (cp < 21'h10000) return 3;
		return 4;
	endfunction

	function automatic logic [CP_W-1:0] pick_cp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 20) return CP_W'($urandom_range(0, 'h7F));
		if (r < 35) return CP_W'($urandom_range('h80, 'hFF));
		if (r < 50) return notable_cps[$urandom_range(0, notable_cps.size() - 1)];
		if (r < 60) return CP_W'($urandom_range('h2500, 'h257F));
		if (r < 65) return CP_W'($urandom_range('h2580, 'h259F));
		if (r < 75) return CP_W'($urandom_range('h25A0, 'h27BF));
		if (r < 85) return CP_W'($urandom_range(0, 'hFFFF));
		return CP_W'($urandom_range(0, 'h1FFFFF));
	endfunction

	task automatic wait_all_chars();
		byte_valid <= 1'b0;
		while (fp.due_chars.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && char_valid && !char_stall) begin
				fp.match_char(ascii_char);
			end
			if (long_hold_go) begin
				hold_left    = 300;
				long_hold_go = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				char_stall <= 1'b1;
			end else begin
				char_stall <= idle_on && ($urandom_range(0, 99) < 8);
			end
		end
	end

	initial begin
		logic [BYTE_W-1:0] directed[$];
		logic [CP_W-1:0]   cp;
		int                len;
		int                r;
		bit                held;
		bit                paused;
		directed = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF, 8'hF8,
			8'hC3, 8'hA9, 8'hC2, 8'hA0, 8'hE2, 8'h80, 8'h94,
			8'hE2, 8'h94, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hE2, 8'h41, 8'hC0, 8'h80, 8'hC3, 8'h00};
		notable_cps = '{21'h00A0, 21'h2018, 21'h2019, 21'h201C, 21'h201D, 21'h2013,
			21'h2014, 21'h2026, 21'h2022, 21'h00B7, 21'h2190, 21'h2191, 21'h2192,
			21'h2193, 21'h2713, 21'h2714, 21'h2715, 21'h2716, 21'h2717, 21'h2718,
			21'h00B0, 21'h00B1, 21'h00BB, 21'h00AB, 21'h2500, 21'h2502, 21'h2504,
			21'h2507, 21'h250A, 21'h250B, 21'h250C, 21'h254C, 21'h254F, 21'h007F,
			21'h0080, 21'h00BF, 21'h00C0, 21'h00FF, 21'h0100, 21'h24FF, 21'h2580,
			21'h259F, 21'h25A0, 21'h25FF, 21'h2600, 21'h27BF, 21'h27C0, 21'h1FFFFF};
		held   = 1'b0;
		paused = 1'b0;
		arst_n     <= 1'b0;
		byte_valid <= 1'b0;
		in_byte    <= '0;
		char_stall <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			send_byte(directed[i]);
		end

		while (good_bytes < 700) begin
			idle_on = (good_bytes < 450 || good_bytes > 580);
			if (!held && good_bytes >= 200) begin
				held         = 1'b1;
				long_hold_go = 1'b1;
			end
			if (!paused && good_bytes >= 350) begin
				paused = 1'b1;
				wait_all_chars();
			end
			r = $urandom_range(0, 99);
			if (r < 88) begin
				cp  = pick_cp();
				len = min_len(cp);
				if (len < 4 && $urandom_range(0, 9) == 0) begin
					len = $urandom_range(len + 1, 4);
				end
				send_code_point(cp, len, len);
			end else if (r < 92) begin
				// sequence cut short
				len = $urandom_range(2, 4);
				send_code_point(CP_W'($urandom_range(0, 'h1FFFFF)), len,
					$urandom_range(1, len - 1));
			end else if (r < 95) begin
				send_byte(BYTE_W'($urandom_range('h80, 'hBF)));
			end else if (r < 97) begin
				send_byte(BYTE_W'($urandom_range('hF8, 'hFF)));
			end else begin
				send_byte(BYTE_W'($urandom_range(0, 255)));
			end
		end

		idle_on = 1'b1;
		wait_all_chars();
		repeat (10) @(posedge clk);
		if (fp.bad_chars == 0 && fp.due_chars.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ----- utf8_to_ascii_folder.f -----
+incdir+sv
sv/u2a_pkg.sv
sv/utf8_to_ascii_folder.sv
sv/u2a_checker.sv
sim/tb_top.sv
